### rtl/core/vector_rotate_2d_core_defines.svh
// Assertion macros for the 2D vector rotation core.
// Used by vector_rotate_2d_core.sv; needs a clock and an active-low reset at the use site.
`ifndef VECTOR_ROTATE_2D_CORE_DEFINES_SVH
`define VECTOR_ROTATE_2D_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define VR2D_ASSERT_HOLDS(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define VR2D_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/vr2d_pkg.sv
// Package for the 2D vector rotation core: widths, gain and arctangent constants.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package vr2d_pkg;

    localparam int ITERATIONS_DEF  = 16;
    localparam int COORD_WIDTH_DEF = 16;
    localparam int MAX_ITERATIONS  = 24;
    localparam int GUARD           = 16;   // extra fraction bits in the datapath
    localparam int ANGLE_WIDTH     = 16;   // binary angle, full turn = 2^16
    localparam int Z_WIDTH         = 33;   // residual angle, full turn = 2^32
    localparam int KGAIN_WIDTH     = 32;

    // CORDIC limit gain 0.607252935 in Q0.32
    localparam logic [KGAIN_WIDTH-1:0] KGAIN = 32'h9B74EDA8;

    // atan(2^-i) with a full turn = 2^32, rounded to nearest
    function automatic logic [31:0] atan_lut(input int idx);
        logic [31:0] v;
        unique case (idx)
            0:       v = 32'h20000000;
            1:       v = 32'h12E4051E;
            2:       v = 32'h09FB385B;
            3:       v = 32'h051111D4;
            4:       v = 32'h028B0D43;
            5:       v = 32'h0145D7E1;
            6:       v = 32'h00A2F61E;
            7:       v = 32'h00517C55;
            8:       v = 32'h0028BE53;
            9:       v = 32'h00145F2F;
            10:      v = 32'h000A2F98;
            11:      v = 32'h000517CC;
            12:      v = 32'h00028BE6;
            13:      v = 32'h000145F3;
            14:      v = 32'h0000A2FA;
            15:      v = 32'h0000517D;
            16:      v = 32'h000028BE;
            17:      v = 32'h0000145F;
            18:      v = 32'h00000A30;
            19:      v = 32'h00000518;
            20:      v = 32'h0000028C;
            21:      v = 32'h00000146;
            22:      v = 32'h000000A3;
            23:      v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // Saturation magnitude: floor(sqrt(2^(2*cw-1))) + 1, evaluated at elaboration
    function automatic logic [63:0] mag_limit(input int cw);
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] c;
        n = 64'd1 << (2 * cw - 1);
        r = 64'd0;
        for (int b = 31; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (c * c <= n) begin
                r = c;
            end
        end
        return r + 64'd1;
    endfunction

endpackage

### rtl/core/vr2d_ifs.sv
// Valid/ready channel interfaces for the 2D vector rotation core.
// Depends on vr2d_pkg for default widths.
`timescale 1ns / 1ps

// Request channel: vector and rotation angle
interface vr2d_in_if #(
    parameter int COORD_WIDTH = vr2d_pkg::COORD_WIDTH_DEF
);
    import vr2d_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] x_in;
    logic signed [COORD_WIDTH-1:0] y_in;
    logic [ANGLE_WIDTH-1:0]        angle;

    modport source (output valid, output x_in, output y_in, output angle, input ready);
    modport sink   (input valid, input x_in, input y_in, input angle, output ready);
endinterface

// Result channel: rotated vector, one extra integer bit
interface vr2d_out_if #(
    parameter int COORD_WIDTH = vr2d_pkg::COORD_WIDTH_DEF
);
    import vr2d_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [COORD_WIDTH:0] x_out;
    logic signed [COORD_WIDTH:0] y_out;

    modport source (output valid, output x_out, output y_out, input ready);
    modport sink   (input valid, input x_out, input y_out, output ready);
endinterface

### rtl/core/vector_rotate_2d_core.sv
// Pipelined CORDIC 2D vector rotation with gain compensation and saturation.
// Depends on vr2d_pkg, vr2d_ifs.sv and vector_rotate_2d_core_defines.svh.
`timescale 1ns / 1ps
`include "vector_rotate_2d_core_defines.svh"

// Usage:
//   i_req carries one request per valid/ready handshake: x_in, y_in (signed
//   COORD_WIDTH bits) and angle (16-bit binary angle, counterclockwise).
//   o_res returns one result per request, in order: x_out, y_out, rounded to
//   nearest and clamped to +-ceil(sqrt(2) * 2^(COORD_WIDTH-1)).
//   The pipeline has one pre-rotation stage, one stage per CORDIC iteration,
//   then magnitude, gain multiply (split into two partial products),
//   rounding and clamp stages.
//   Throughput: one request per cycle while o_res.ready stays high.
//   Stall: a one-entry skid register behind the last stage catches the item
//   that would be overwritten; while it is occupied the whole pipeline holds
//   and i_req.ready is low. i_req.ready comes straight from a flop, so there
//   is no combinational path from o_res.ready to i_req.ready.
//   Reset (i_rst_n low, synchronous) empties the pipeline and the skid
//   register; no results are pending afterwards.
module vector_rotate_2d_core #(
    parameter int ITERATIONS  = vr2d_pkg::ITERATIONS_DEF,
    parameter int COORD_WIDTH = vr2d_pkg::COORD_WIDTH_DEF
) (
    input logic         i_clk,
    input logic         i_rst_n,
    vr2d_in_if.sink     i_req,
    vr2d_out_if.source  o_res
);
    import vr2d_pkg::*;

    // Datapath widths
    localparam int XW   = COORD_WIDTH + GUARD + 3;          // coordinate with gain headroom
    localparam int OW   = COORD_WIDTH + 1;
    localparam int PW   = (XW > KGAIN_WIDTH) ? XW : KGAIN_WIDTH + 1;
    localparam int HW   = PW - KGAIN_WIDTH;                  // upper partial operand
    localparam int TW   = HW + KGAIN_WIDTH + 1;              // scaled product
    localparam int RW   = TW - GUARD;                        // rounded magnitude
    localparam int VW   = RW + 1;                            // signed result before clamp
    localparam int ZPAD = Z_WIDTH - ANGLE_WIDTH - 1;

    // Stage indexes
    localparam int ST_RND = ITERATIONS + 3;
    localparam int ST_OUT = ITERATIONS + 4;
    localparam int NSTG   = ITERATIONS + 5;

    localparam logic [63:0]             LIMIT_U = mag_limit(COORD_WIDTH);
    localparam logic signed [VW-1:0]    LIMIT_V = $signed(VW'(LIMIT_U));
    localparam logic signed [OW-1:0]    LIMIT_O = $signed(OW'(LIMIT_U));

    localparam logic signed [ANGLE_WIDTH:0] A_QUARTER =
        $signed((ANGLE_WIDTH + 1)'(1) << (ANGLE_WIDTH - 2));
    localparam logic signed [ANGLE_WIDTH:0] A_HALF =
        $signed((ANGLE_WIDTH + 1)'(1) << (ANGLE_WIDTH - 1));
    localparam logic [TW-1:0] RND_HALF = TW'(1) << (GUARD - 1);

    // Flow control
    logic              w_en;
    logic              w_acc;
    logic [NSTG-1:0]   r_vld;
    logic              r_skid_vld;
    logic              n_skid_vld;
    logic              w_skid_load;

    // Stage registers
    logic signed [XW-1:0]      r_x [ITERATIONS+1];
    logic signed [XW-1:0]      r_y [ITERATIONS+1];
    logic signed [Z_WIDTH-1:0] r_z [ITERATIONS+1];

    logic                      r_neg_a_x, r_neg_a_y;
    logic [PW-1:0]             r_mag_x, r_mag_y;
    logic                      r_neg_m_x, r_neg_m_y;
    logic [2*KGAIN_WIDTH-1:0]  r_plo_x, r_plo_y;
    logic [HW+KGAIN_WIDTH-1:0] r_phi_x, r_phi_y;
    logic                      r_neg_r_x, r_neg_r_y;
    logic [RW-1:0]             r_rnd_x, r_rnd_y;
    logic signed [OW-1:0]      r_xo, r_yo;
    logic signed [OW-1:0]      r_skid_x, r_skid_y;

    // Handshake: ready is the registered skid-empty flag
    assign w_en        = !r_skid_vld;
    assign w_acc       = i_req.valid && w_en;
    assign i_req.ready = w_en;

    assign w_skid_load = !r_skid_vld && r_vld[ST_OUT] && !o_res.ready;

    always_comb begin
        n_skid_vld = r_skid_vld;
        if (w_skid_load) begin
            n_skid_vld = 1'b1;
        end else if (r_skid_vld && o_res.ready) begin
            n_skid_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_skid_vld <= 1'b0;
        end else begin
            if (w_en) begin
                r_vld <= {r_vld[NSTG-2:0], w_acc};
            end
            r_skid_vld <= n_skid_vld;
        end
    end

    // Pre-rotation: fold angles beyond a quarter turn by a half turn
    logic signed [ANGLE_WIDTH:0] n_ang;
    logic                        n_flip;
    logic signed [XW-1:0]        n_xs, n_ys;

    always_comb begin
        n_ang  = $signed({i_req.angle[ANGLE_WIDTH-1], i_req.angle});
        n_flip = 1'b0;
        if (n_ang > A_QUARTER) begin
            n_ang  = n_ang - A_HALF;
            n_flip = 1'b1;
        end else if (n_ang < -A_QUARTER) begin
            n_ang  = n_ang + A_HALF;
            n_flip = 1'b1;
        end
        n_xs = $signed({{3{i_req.x_in[COORD_WIDTH-1]}}, i_req.x_in, {GUARD{1'b0}}});
        n_ys = $signed({{3{i_req.y_in[COORD_WIDTH-1]}}, i_req.y_in, {GUARD{1'b0}}});
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x[0] <= n_flip ? -n_xs : n_xs;
            r_y[0] <= n_flip ? -n_ys : n_ys;
            r_z[0] <= $signed({n_ang, {ZPAD{1'b0}}});
        end
    end

    // CORDIC micro-rotations, one per stage
    for (genvar k = 1; k <= ITERATIONS; k++) begin : g_iter
        localparam logic signed [Z_WIDTH-1:0] ATAN_K = $signed({1'b0, atan_lut(k - 1)});

        logic signed [XW-1:0]      n_dx, n_dy;
        logic signed [XW-1:0]      n_x, n_y;
        logic signed [Z_WIDTH-1:0] n_z;

        always_comb begin
            n_dx = r_y[k-1] >>> (k - 1);
            n_dy = r_x[k-1] >>> (k - 1);
            if (!r_z[k-1][Z_WIDTH-1]) begin
                n_x = r_x[k-1] - n_dx;
                n_y = r_y[k-1] + n_dy;
                n_z = r_z[k-1] - ATAN_K;
            end else begin
                n_x = r_x[k-1] + n_dx;
                n_y = r_y[k-1] - n_dy;
                n_z = r_z[k-1] + ATAN_K;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_x[k] <= n_x;
                r_y[k] <= n_y;
                r_z[k] <= n_z;
            end
        end
    end

    // Sign and magnitude ahead of the gain multiply
    logic signed [XW-1:0] n_ax, n_ay;

    always_comb begin
        n_ax = r_x[ITERATIONS][XW-1] ? -r_x[ITERATIONS] : r_x[ITERATIONS];
        n_ay = r_y[ITERATIONS][XW-1] ? -r_y[ITERATIONS] : r_y[ITERATIONS];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_neg_a_x <= r_x[ITERATIONS][XW-1];
            r_neg_a_y <= r_y[ITERATIONS][XW-1];
            r_mag_x   <= PW'($unsigned(n_ax));
            r_mag_y   <= PW'($unsigned(n_ay));
        end
    end

    // Gain multiply as two partial products of at most 32 x 32 bits
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_neg_m_x <= r_neg_a_x;
            r_neg_m_y <= r_neg_a_y;
            r_plo_x   <= (2*KGAIN_WIDTH)'(r_mag_x[KGAIN_WIDTH-1:0])
                         * (2*KGAIN_WIDTH)'(KGAIN);
            r_plo_y   <= (2*KGAIN_WIDTH)'(r_mag_y[KGAIN_WIDTH-1:0])
                         * (2*KGAIN_WIDTH)'(KGAIN);
            r_phi_x   <= (HW+KGAIN_WIDTH)'(r_mag_x[PW-1:KGAIN_WIDTH])
                         * (HW+KGAIN_WIDTH)'(KGAIN);
            r_phi_y   <= (HW+KGAIN_WIDTH)'(r_mag_y[PW-1:KGAIN_WIDTH])
                         * (HW+KGAIN_WIDTH)'(KGAIN);
        end
    end

    // Combine partials, drop 32 + GUARD bits with round half up on the magnitude
    logic [TW-1:0] n_tx, n_ty;

    always_comb begin
        n_tx = TW'(r_phi_x) + TW'(r_plo_x >> KGAIN_WIDTH) + RND_HALF;
        n_ty = TW'(r_phi_y) + TW'(r_plo_y >> KGAIN_WIDTH) + RND_HALF;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_neg_r_x <= r_neg_m_x;
            r_neg_r_y <= r_neg_m_y;
            r_rnd_x   <= RW'(n_tx >> GUARD);
            r_rnd_y   <= RW'(n_ty >> GUARD);
        end
    end

    // Restore sign and clamp to the output range
    function automatic logic signed [OW-1:0] sat_out(input logic neg, input logic [RW-1:0] mag);
        logic signed [VW-1:0] v;
        v = $signed(VW'(mag));
        if (neg) begin
            v = -v;
        end
        if (v > LIMIT_V) begin
            v = LIMIT_V;
        end else if (v < -LIMIT_V) begin
            v = -LIMIT_V;
        end
        return $signed(OW'(v));
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_xo <= sat_out(r_neg_r_x, r_rnd_x);
            r_yo <= sat_out(r_neg_r_y, r_rnd_y);
        end
    end

    // Skid register holds the older result while the pipeline is frozen
    always_ff @(posedge i_clk) begin
        if (w_skid_load) begin
            r_skid_x <= r_xo;
            r_skid_y <= r_yo;
        end
    end

    assign o_res.valid = r_skid_vld || r_vld[ST_OUT];
    assign o_res.x_out = r_skid_vld ? r_skid_x : r_xo;
    assign o_res.y_out = r_skid_vld ? r_skid_y : r_yo;

    // Checks
    `VR2D_ASSERT_NEXT(a_skid_hold, i_clk, i_rst_n, r_skid_vld && !o_res.ready, r_skid_vld && $stable(o_res.x_out), "stalled skid result changed")
    `VR2D_ASSERT_NEXT(a_frozen_hold, i_clk, i_rst_n, !w_en, $stable(r_vld), "pipeline advanced while skid full")
    `VR2D_ASSERT_HOLDS(a_x_range, i_clk, i_rst_n, o_res.valid, (o_res.x_out <= LIMIT_O) && (o_res.x_out >= -LIMIT_O), "x_out beyond saturation limit")
    `VR2D_ASSERT_NEXT(a_drain, i_clk, i_rst_n, o_res.valid && o_res.ready && !r_skid_vld && !r_vld[ST_RND], !o_res.valid, "result appeared from an empty stage")

endmodule
